// ----- rtl/sfha_pkg.sv -----
// shared types, codes and size-class helper for the segregated-fit heap allocator
// no dependencies
package sfha_pkg;

    localparam int unsigned N_CLASSES = 10;
    localparam int unsigned NEED_W    = 14;

    typedef logic [3:0] t_bkt;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_NOTUSED = 2'd2;

    // class limits in 16-byte granules (64 .. 16384 bytes)
    localparam logic [31:0] CLASS_LIM_G [N_CLASSES-1] = '{
        32'd4, 32'd8, 32'd16, 32'd32, 32'd64, 32'd128, 32'd256, 32'd512, 32'd1024
    };

    typedef struct packed {
        logic        req_type;
        logic [16:0] req_size;
        logic [15:0] req_addr;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] resp_addr;
    } t_res;

    function automatic t_bkt bucket_of(input logic [31:0] gran);
        t_bkt b;
        b = t_bkt'(N_CLASSES - 1);
        for (int i = N_CLASSES - 2; i >= 0; i--) begin
            if (gran < CLASS_LIM_G[i]) begin
                b = t_bkt'(i);
            end
        end
        return b;
    endfunction

endpackage

// ----- rtl/sfha_if.sv -----
// request and response channel interfaces for the heap allocator
// depends on sfha_pkg
interface sfha_req_if;
    import sfha_pkg::*;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [16:0] req_size;
    logic [15:0] req_addr;
    modport source (output valid, req_type, req_size, req_addr, input ready);
    modport sink   (input valid, req_type, req_size, req_addr, output ready);
endinterface

interface sfha_rsp_if;
    import sfha_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] resp_addr;
    modport source (output valid, status, resp_addr, input ready);
    modport sink   (input valid, status, resp_addr, output ready);
endinterface

// ----- rtl/sfha_ram.sv -----
// simple dual-port synchronous ram, one write and one read port, registered read
// no dependencies
module sfha_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/sfha_ctrl.sv -----
// allocator sequencer: tag memories, list heads, alloc search, split, free and merge
// depends on sfha_pkg and sfha_ram
module sfha_ctrl #(
    parameter int unsigned HEAP_BYTES = 65536
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  sfha_pkg::t_req i_req,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output sfha_pkg::t_res o_res
);
    import sfha_pkg::*;

    localparam int unsigned HEAP_GRAN = (HEAP_BYTES + 15) / 16;
    localparam int unsigned GW = $clog2(HEAP_GRAN);
    localparam int unsigned SW = $clog2(HEAP_GRAN + 1);
    localparam int unsigned CW = ((SW > NEED_W) ? SW : NEED_W) + 1;
    localparam int unsigned XW = (CW > 12) ? CW : 12;

    typedef struct packed {
        logic          used;
        logic          head;
        logic          has_prev;
        logic          has_next;
        logic [SW-1:0] size;
        logic [GW-1:0] prev;
        logic [GW-1:0] next;
    } t_hdr;

    localparam int unsigned HW = $bits(t_hdr);

    typedef enum logic [20:0] {
        S_CLEAR   = 21'h000001,
        S_IDLE    = 21'h000002,
        S_A_SCAN  = 21'h000004,
        S_A_TEST  = 21'h000008,
        S_A_SPLIT = 21'h000010,
        S_A_FIN   = 21'h000020,
        S_F_CHK   = 21'h000040,
        S_F_RCHK  = 21'h000080,
        S_F_RABS  = 21'h000100,
        S_F_LEFT  = 21'h000200,
        S_F_LFOOT = 21'h000400,
        S_F_LCHK  = 21'h000800,
        S_F_LABS  = 21'h001000,
        S_F_INS   = 21'h002000,
        S_RM_P    = 21'h004000,
        S_RM_PW   = 21'h008000,
        S_RM_N    = 21'h010000,
        S_RM_NW   = 21'h020000,
        S_INS     = 21'h040000,
        S_INS_WR  = 21'h080000,
        S_DONE    = 21'h100000
    } t_state;

    t_state r_state, n_state, r_ret, n_ret;
    logic [GW-1:0] r_clr, n_clr;
    logic [GW-1:0] r_bhead [N_CLASSES];
    logic          r_bval  [N_CLASSES];
    logic [NEED_W-1:0] r_need, n_need;
    t_bkt          r_bkt, n_bkt;
    logic [GW-1:0] r_cur, n_cur, r_g, n_g, r_nx, n_nx, r_pb, n_pb;
    logic [GW-1:0] r_ins_g, n_ins_g, r_oldh, n_oldh;
    logic [SW-1:0] r_psize, n_psize, r_ins_size, n_ins_size, r_fsize, n_fsize;
    t_hdr          r_tag, n_tag, r_rm, n_rm, r_nxtag, n_nxtag;
    t_res          r_res, n_res;

    // memory ports
    logic          hdr_we, hdr_re, foot_we, foot_re;
    logic [GW-1:0] hdr_waddr, hdr_raddr, foot_waddr, foot_raddr;
    t_hdr          hdr_wdata, hdr_rdata;
    logic [HW-1:0] hdr_rbits;
    logic [SW-1:0] foot_wdata, foot_rdata;

    // list head access, one bucket per cycle
    t_bkt          bsel;
    logic          b_we, b_wval;
    logic [GW-1:0] b_whead, bh;
    logic          bv;

    // request decode
    logic [16:0]     sz1;
    logic [17:0]     need_full;
    logic [11:0]     fg12;
    logic            fbad;
    logic [CW-1:0]   sum_c;
    logic [SW-1:0]   tot;
    logic [XW-1:0]   gx;

    assign hdr_rdata = t_hdr'(hdr_rbits);

    sfha_ram #(.WIDTH(HW), .DEPTH(HEAP_GRAN)) u_hdr_ram (
        .i_clk  (i_clk),
        .i_we   (hdr_we),
        .i_waddr(hdr_waddr),
        .i_wdata(HW'(hdr_wdata)),
        .i_re   (hdr_re),
        .i_raddr(hdr_raddr),
        .o_rdata(hdr_rbits)
    );

    sfha_ram #(.WIDTH(SW), .DEPTH(HEAP_GRAN)) u_foot_ram (
        .i_clk  (i_clk),
        .i_we   (foot_we),
        .i_waddr(foot_waddr),
        .i_wdata(foot_wdata),
        .i_re   (foot_re),
        .i_raddr(foot_raddr),
        .o_rdata(foot_rdata)
    );

    assign bh = (bsel < t_bkt'(N_CLASSES)) ? r_bhead[bsel] : '0;
    assign bv = (bsel < t_bkt'(N_CLASSES)) ? r_bval[bsel] : 1'b0;

    assign sz1       = (i_req.req_size == '0) ? 17'd1 : i_req.req_size;
    assign need_full = ((18'(sz1) + 18'd15) >> 4) + 18'd3;
    assign fg12      = i_req.req_addr[15:4] - 12'd2;
    assign fbad      = (i_req.req_addr < 16'd32) || (i_req.req_addr[3:0] != 4'd0)
                     || (XW'(fg12) >= XW'(HEAP_GRAN));
    assign gx        = XW'(r_g);

    always_comb begin
        n_state = r_state;  n_ret = r_ret;  n_clr = r_clr;
        n_need = r_need;    n_bkt = r_bkt;  n_cur = r_cur;  n_g = r_g;
        n_nx = r_nx;        n_pb = r_pb;    n_ins_g = r_ins_g;  n_oldh = r_oldh;
        n_psize = r_psize;  n_ins_size = r_ins_size;  n_fsize = r_fsize;
        n_tag = r_tag;      n_rm = r_rm;    n_nxtag = r_nxtag;  n_res = r_res;
        hdr_we = 1'b0;  hdr_waddr = '0;  hdr_wdata = '0;
        hdr_re = 1'b0;  hdr_raddr = '0;
        foot_we = 1'b0; foot_waddr = '0; foot_wdata = '0;
        foot_re = 1'b0; foot_raddr = '0;
        bsel = r_bkt;   b_we = 1'b0;  b_wval = 1'b0;  b_whead = '0;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        sum_c = '0;
        tot   = '0;

        unique case (r_state)
            S_CLEAR: begin
                hdr_we    = 1'b1;
                hdr_waddr = r_clr;
                foot_we   = 1'b1;
                foot_waddr = r_clr;
                if (r_clr == '0) begin
                    hdr_wdata.head = 1'b1;
                    hdr_wdata.size = SW'(HEAP_GRAN);
                end
                if (r_clr == GW'(HEAP_GRAN - 1)) begin
                    foot_wdata = SW'(HEAP_GRAN);
                    n_state    = S_IDLE;
                end
                n_clr = r_clr + GW'(1);
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    if (i_req.req_type == REQ_ALLOC) begin
                        n_need = NEED_W'(need_full);
                        if (CW'(need_full) > CW'(HEAP_GRAN)) begin
                            n_res   = '{status: ST_NOFIT, resp_addr: '0};
                            n_state = S_DONE;
                        end else begin
                            n_bkt   = bucket_of(32'(need_full));
                            n_state = S_A_SCAN;
                        end
                    end else begin
                        if (fbad) begin
                            n_res   = '{status: ST_NOTUSED, resp_addr: '0};
                            n_state = S_DONE;
                        end else begin
                            hdr_re    = 1'b1;
                            hdr_raddr = GW'(fg12);
                            n_g       = GW'(fg12);
                            n_state   = S_F_CHK;
                        end
                    end
                end
            end
            S_A_SCAN: begin
                if (r_bkt >= t_bkt'(N_CLASSES)) begin
                    n_res   = '{status: ST_NOFIT, resp_addr: '0};
                    n_state = S_DONE;
                end else if (bv) begin
                    hdr_re    = 1'b1;
                    hdr_raddr = bh;
                    n_cur     = bh;
                    n_state   = S_A_TEST;
                end else begin
                    n_bkt = r_bkt + t_bkt'(1);
                end
            end
            S_A_TEST: begin
                if (CW'(hdr_rdata.size) >= CW'(r_need)) begin
                    n_g     = r_cur;
                    n_tag   = hdr_rdata;
                    n_rm    = hdr_rdata;
                    n_ret   = S_A_SPLIT;
                    n_state = S_RM_P;
                end else if (hdr_rdata.has_next) begin
                    hdr_re    = 1'b1;
                    hdr_raddr = hdr_rdata.next;
                    n_cur     = hdr_rdata.next;
                end else begin
                    n_bkt   = r_bkt + t_bkt'(1);
                    n_state = S_A_SCAN;
                end
            end
            S_A_SPLIT: begin
                if (CW'(r_tag.size) >= CW'(r_need) + CW'(4)) begin
                    n_ins_g    = GW'(CW'(r_g) + CW'(r_need));
                    n_ins_size = SW'(CW'(r_tag.size) - CW'(r_need));
                    foot_we    = 1'b1;
                    foot_waddr = GW'(CW'(r_g) + CW'(r_tag.size) - CW'(1));
                    foot_wdata = SW'(CW'(r_tag.size) - CW'(r_need));
                    n_fsize    = SW'(r_need);
                    n_ret      = S_A_FIN;
                    n_state    = S_INS;
                end else begin
                    n_fsize = r_tag.size;
                    n_state = S_A_FIN;
                end
            end
            S_A_FIN: begin
                hdr_we         = 1'b1;
                hdr_waddr      = r_g;
                hdr_wdata.used = 1'b1;
                hdr_wdata.head = 1'b1;
                hdr_wdata.size = r_fsize;
                foot_we        = 1'b1;
                foot_waddr     = GW'(CW'(r_g) + CW'(r_fsize) - CW'(1));
                foot_wdata     = r_fsize;
                n_res          = '{status: ST_OK, resp_addr: {gx[11:0] + 12'd2, 4'h0}};
                n_state        = S_DONE;
            end
            S_F_CHK: begin
                if (!hdr_rdata.head || !hdr_rdata.used) begin
                    n_res   = '{status: ST_NOTUSED, resp_addr: '0};
                    n_state = S_DONE;
                end else begin
                    n_tag      = hdr_rdata;
                    n_tag.used = 1'b0;
                    sum_c      = CW'(r_g) + CW'(hdr_rdata.size);
                    if (sum_c < CW'(HEAP_GRAN)) begin
                        hdr_re    = 1'b1;
                        hdr_raddr = GW'(sum_c);
                        n_nx      = GW'(sum_c);
                        n_state   = S_F_RCHK;
                    end else begin
                        n_state = S_F_LEFT;
                    end
                end
            end
            S_F_RCHK: begin
                if (hdr_rdata.head && !hdr_rdata.used) begin
                    n_rm       = hdr_rdata;
                    n_nxtag    = hdr_rdata;
                    n_tag.size = SW'(CW'(r_tag.size) + CW'(hdr_rdata.size));
                    n_ret      = S_F_RABS;
                    n_state    = S_RM_P;
                end else begin
                    n_state = S_F_LEFT;
                end
            end
            S_F_RABS: begin
                // right neighbour loses its header, merged size goes in the footer
                hdr_we         = 1'b1;
                hdr_waddr      = r_nx;
                hdr_wdata.used = r_nxtag.used;
                hdr_wdata.size = r_nxtag.size;
                foot_we        = 1'b1;
                foot_waddr     = GW'(CW'(r_g) + CW'(r_tag.size) - CW'(1));
                foot_wdata     = r_tag.size;
                n_state        = S_F_LEFT;
            end
            S_F_LEFT: begin
                if (r_g != '0) begin
                    foot_re    = 1'b1;
                    foot_raddr = r_g - GW'(1);
                    n_state    = S_F_LFOOT;
                end else begin
                    n_state = S_F_INS;
                end
            end
            S_F_LFOOT: begin
                if (foot_rdata != '0 && CW'(foot_rdata) <= CW'(r_g)) begin
                    hdr_re    = 1'b1;
                    hdr_raddr = GW'(CW'(r_g) - CW'(foot_rdata));
                    n_pb      = GW'(CW'(r_g) - CW'(foot_rdata));
                    n_state   = S_F_LCHK;
                end else begin
                    n_state = S_F_INS;
                end
            end
            S_F_LCHK: begin
                if (hdr_rdata.head && !hdr_rdata.used) begin
                    n_rm    = hdr_rdata;
                    n_psize = hdr_rdata.size;
                    n_ret   = S_F_LABS;
                    n_state = S_RM_P;
                end else begin
                    n_state = S_F_INS;
                end
            end
            S_F_LABS: begin
                tot            = SW'(CW'(r_psize) + CW'(r_tag.size));
                hdr_we         = 1'b1;
                hdr_waddr      = r_g;
                hdr_wdata      = r_tag;
                hdr_wdata.head = 1'b0;
                foot_we        = 1'b1;
                foot_waddr     = GW'(CW'(r_pb) + CW'(tot) - CW'(1));
                foot_wdata     = tot;
                n_g            = r_pb;
                n_ins_g        = r_pb;
                n_ins_size     = tot;
                n_res          = '{status: ST_OK, resp_addr: '0};
                n_ret          = S_DONE;
                n_state        = S_INS;
            end
            S_F_INS: begin
                n_ins_g    = r_g;
                n_ins_size = r_tag.size;
                n_res      = '{status: ST_OK, resp_addr: '0};
                n_ret      = S_DONE;
                n_state    = S_INS;
            end
            S_RM_P: begin
                bsel = bucket_of(32'(r_rm.size));
                if (r_rm.has_prev) begin
                    hdr_re    = 1'b1;
                    hdr_raddr = r_rm.prev;
                    n_state   = S_RM_PW;
                end else begin
                    b_we    = 1'b1;
                    b_whead = r_rm.next;
                    b_wval  = r_rm.has_next;
                    n_state = S_RM_N;
                end
            end
            S_RM_PW: begin
                hdr_we             = 1'b1;
                hdr_waddr          = r_rm.prev;
                hdr_wdata          = hdr_rdata;
                hdr_wdata.next     = r_rm.next;
                hdr_wdata.has_next = r_rm.has_next;
                n_state            = S_RM_N;
            end
            S_RM_N: begin
                if (r_rm.has_next) begin
                    hdr_re    = 1'b1;
                    hdr_raddr = r_rm.next;
                    n_state   = S_RM_NW;
                end else begin
                    n_state = r_ret;
                end
            end
            S_RM_NW: begin
                hdr_we             = 1'b1;
                hdr_waddr          = r_rm.next;
                hdr_wdata          = hdr_rdata;
                hdr_wdata.prev     = r_rm.prev;
                hdr_wdata.has_prev = r_rm.has_prev;
                n_state            = r_ret;
            end
            S_INS: begin
                bsel               = bucket_of(32'(r_ins_size));
                hdr_we             = 1'b1;
                hdr_waddr          = r_ins_g;
                hdr_wdata.head     = 1'b1;
                hdr_wdata.size     = r_ins_size;
                hdr_wdata.has_next = bv;
                hdr_wdata.next     = bh;
                b_we               = 1'b1;
                b_whead            = r_ins_g;
                b_wval             = 1'b1;
                if (bv) begin
                    hdr_re    = 1'b1;
                    hdr_raddr = bh;
                    n_oldh    = bh;
                    n_state   = S_INS_WR;
                end else begin
                    n_state = r_ret;
                end
            end
            S_INS_WR: begin
                hdr_we             = 1'b1;
                hdr_waddr          = r_oldh;
                hdr_wdata          = hdr_rdata;
                hdr_wdata.prev     = r_ins_g;
                hdr_wdata.has_prev = 1'b1;
                n_state            = r_ret;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ret   <= S_IDLE;
            r_clr   <= '0;
            // only the class of the whole heap's size starts with the whole heap
            for (int i = 0; i < N_CLASSES; i++) begin
                r_bval[i]  <= (t_bkt'(i) == bucket_of(32'(HEAP_GRAN)));
                r_bhead[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_clr   <= n_clr;
            if (b_we && bsel < t_bkt'(N_CLASSES)) begin
                r_bhead[bsel] <= b_whead;
                r_bval[bsel]  <= b_wval;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_need     <= n_need;
        r_bkt      <= n_bkt;
        r_cur      <= n_cur;
        r_g        <= n_g;
        r_nx       <= n_nx;
        r_pb       <= n_pb;
        r_ins_g    <= n_ins_g;
        r_oldh     <= n_oldh;
        r_psize    <= n_psize;
        r_ins_size <= n_ins_size;
        r_fsize    <= n_fsize;
        r_tag      <= n_tag;
        r_rm       <= n_rm;
        r_nxtag    <= n_nxtag;
        r_res      <= n_res;
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_req_valid) |=> r_state != S_IDLE)
        else $error("request accepted but sequencer stayed idle");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status != ST_OK) |-> o_res.resp_addr == '0)
        else $error("failed request carries a nonzero address");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!hdr_we && !foot_we && !b_we))
        else $error("tag or list write while idle");

    a_clear_blocks_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!o_req_ready && !o_res_valid))
        else $error("request handshake during clearing pass");

endmodule

// ----- rtl/segregated_fit_heap_allocator.sv -----
// segregated-fit heap allocator top level: channel ports, sequencer, response register
// allocate: scan classes from the request's class upward, walking each list; unlink the fit,
// split off and insert any remainder, write its tags; oversized allocate or bad free address
// respond directly, free of an unused block after its tag check, other frees after merges
// throughput: one request at a time; the next is taken the cycle after the sequencer passes on its result
// reset: synchronous active-low; then a clearing pass over every tag and footer entry
module segregated_fit_heap_allocator #(
    parameter int unsigned HEAP_BYTES = 65536
) (
    input logic        i_clk,
    input logic        i_rst_n,
    sfha_req_if.sink   i_req,
    sfha_rsp_if.source o_rsp
);
    import sfha_pkg::*;

    t_req  req;
    t_res  res;
    logic  res_valid, res_ready;
    logic  r_out_valid;
    t_res  r_out;

    assign req = '{req_type: i_req.req_type, req_size: i_req.req_size,
                   req_addr: i_req.req_addr};

    sfha_ctrl #(.HEAP_BYTES(HEAP_BYTES)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req.valid),
        .o_req_ready(i_req.ready),
        .i_req      (req),
        .o_res_valid(res_valid),
        .i_res_ready(res_ready),
        .o_res      (res)
    );

    // output register frees the sequencer while a result waits
    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out.status;
    assign o_rsp.resp_addr = r_out.resp_addr;
endmodule
